// ----- rtl/core/ule_pkg.sv -----
// ----------------------------------------------------------------------------
// ULE deframer package
// Shared widths, constants, codes, result struct and the CRC-32 byte update.
// ----------------------------------------------------------------------------
package ule_pkg;

  localparam int unsigned CELL_BYTES = 188;
  localparam int unsigned POS_W      = $clog2(CELL_BYTES);

  localparam logic [7:0]  SYNC_MARK     = 8'h47;
  localparam logic [7:0]  PAYLOAD_BYTES = 8'd184;
  localparam logic [7:0]  PTR_LIMIT     = 8'd183;
  localparam logic [7:0]  LAST_PAYLOAD  = 8'd187;
  localparam logic [31:0] CRC_POLY      = 32'h04C11DB7;
  localparam logic [14:0] MIN_LEN       = 15'd5;

  typedef enum logic [1:0] {
    K_PDU   = 2'd0,
    K_GOOD  = 2'd1,
    K_BAD   = 2'd2,
    K_ABORT = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    F_NONE       = 3'd0,
    F_BAD_CELL   = 3'd1,
    F_CC_GAP     = 3'd2,
    F_BAD_PTR    = 3'd3,
    F_SHORT      = 3'd4,
    F_INCOMPLETE = 3'd5,
    F_PACKING    = 3'd6
  } fault_t;

  typedef enum logic [2:0] {
    PH_LEN_HI  = 3'd0,
    PH_LEN_LO  = 3'd1,
    PH_TYPE_HI = 3'd2,
    PH_TYPE_LO = 3'd3,
    PH_PDU     = 3'd4,
    PH_PAD     = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    MODE_HDR        = 3'd0,
    MODE_SKIP       = 3'd1,
    MODE_PTR_SYNC   = 3'd2,
    MODE_PTR_PACKED = 3'd3,
    MODE_DATA       = 3'd4
  } mode_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  pdu_byte;
    logic [15:0] sndu_type;
    logic        dest_absent;
    logic [14:0] pdu_length;
    logic [2:0]  fault_code;
    logic        last_of_sndu;
  } result_t;

  // CRC-32/MPEG-2, one byte, MSB first.
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {b, 24'd0};
    for (int i = 0; i < 8; i++) begin
      r = r[31] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/ule_sndu_ts_deframer.sv -----
// ----------------------------------------------------------------------------
// ULE SNDU deframer over transport stream cells
// Parses ULE SNDUs from single-PID cells and streams PDU bytes and verdicts.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel takes one cell byte per beat (s_axis_tdata) with
// s_axis_tuser marking the first byte of a cell. The master channel gives
// at most one result beat per input beat: a PDU byte, an SNDU end verdict
// (CRC good or bad) or an abort with a fault code. m_axis_tuser carries the
// result kind and m_axis_tlast is high on the beat that closes an SNDU.
// Throughput is one byte per cycle unless the input is held off as described
// below. A result passes through the parser's result register and then the
// output stage before it appears on the master side.
// The input is held off while the skid register of the output stage is full,
// or while the output register is stalled and a result waits in the parser's
// result register, so a stalled receiver backs up into the slave channel
// after two results.
// Reset clears the parser to wait for a cell carrying PUSI and empties the
// output stage.
// ----------------------------------------------------------------------------
module ule_sndu_ts_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // ts_byte
  input  logic        s_axis_tuser,   // cell_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // pdu_byte, sndu_type, dest_absent, pdu_length,
                                      // fault_code, then 5 zero bits
  output logic [1:0]  m_axis_tuser,   // out_kind
  output logic        m_axis_tlast    // last_of_sndu
);

  logic             in_acc;
  logic             res_valid;
  ule_pkg::result_t res;
  logic             skid_ready;
  ule_pkg::result_t out_r;

  // Ready when the output stage can absorb both the pending and a new result.
  assign s_axis_tready = skid_ready && !(res_valid && m_axis_tvalid && !m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  ule_core u_core (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_acc),
    .ts_byte    (s_axis_tdata),
    .cell_start (s_axis_tuser),
    .res_valid  (res_valid),
    .res        (res)
  );

  ule_out_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_data   (res),
    .in_ready  (skid_ready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_r)
  );

  assign m_axis_tdata = {5'd0, out_r.fault_code, out_r.pdu_length, out_r.dest_absent,
                         out_r.sndu_type, out_r.pdu_byte};
  assign m_axis_tuser = out_r.kind;
  assign m_axis_tlast = out_r.last_of_sndu;

`ifndef SYNTH
  // A PDU beat never closes an SNDU and never carries a fault.
  a_pdu_clean: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == ule_pkg::K_PDU) |->
      (!m_axis_tlast && m_axis_tdata[42:40] == ule_pkg::F_NONE))
    else $error("pdu beat with tlast or fault");
  // Verdicts always close an SNDU.
  a_verdict_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == ule_pkg::K_GOOD ||
                       m_axis_tuser == ule_pkg::K_BAD)) |-> m_axis_tlast)
    else $error("verdict without tlast");
  // A result never appears without an accepted input in the cycle before.
  a_res_cause: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $past(in_acc))
    else $error("result without input");
`endif

endmodule

// ----- rtl/core/ule_out_skid.sv -----
// ----------------------------------------------------------------------------
// ULE output skid buffer
// Two-entry register stage between the deframer core and the result channel.
// ----------------------------------------------------------------------------
module ule_out_skid (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  ule_pkg::result_t in_data,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output ule_pkg::result_t out_data
);

  ule_pkg::result_t main_data;
  ule_pkg::result_t skid_data;
  logic             main_valid;
  logic             skid_valid;

  assign in_ready  = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  // Main register feeds the port; the skid register holds a beat taken while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!main_valid || out_ready) begin
        if (skid_valid) begin
          main_data  <= skid_data;
          main_valid <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          main_data  <= in_data;
          main_valid <= in_valid;
        end
      end else if (in_valid && !skid_valid) begin
        skid_data  <= in_data;
        skid_valid <= 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/ule_core.sv -----
// ----------------------------------------------------------------------------
// ULE deframer core
// Per-byte cell header checks, pointer resync and SNDU parsing in one pass.
// ----------------------------------------------------------------------------
module ule_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [7:0]       ts_byte,
  input  logic             cell_start,
  output logic             res_valid,
  output ule_pkg::result_t res
);

  logic [ule_pkg::POS_W-1:0] cell_position, cell_position_next;
  logic                      need_sync, need_sync_next;
  logic [3:0]                expected_cc, expected_cc_next;
  ule_pkg::phase_t           parse_phase, parse_phase_next;
  logic [7:0]                pointer_skip, pointer_skip_next;
  logic [14:0]               sndu_length, sndu_length_next;
  logic [15:0]               bytes_remaining, bytes_remaining_next;
  logic [15:0]               type_value, type_value_next;
  logic                      dbit_flag, dbit_flag_next;
  logic [31:0]               crc_accum, crc_accum_next;
  logic [31:0]               received_crc, received_crc_next;
  logic                      sndu_active, sndu_active_next;
  ule_pkg::mode_t            cell_mode, cell_mode_next;
  logic                      cell_bad, cell_bad_next;
  logic                      cell_pusi, cell_pusi_next;
  logic [7:0]                len_hi, len_hi_next;

  logic                      emit_v;
  ule_pkg::result_t          emit_r;
  logic [ule_pkg::POS_W-1:0] idx;
  logic [15:0]               w;
  logic [15:0]               rem_dec;
  logic                      do_sync_start;

  always_comb begin
    cell_position_next   = cell_position;
    need_sync_next       = need_sync;
    expected_cc_next     = expected_cc;
    parse_phase_next     = parse_phase;
    pointer_skip_next    = pointer_skip;
    sndu_length_next     = sndu_length;
    bytes_remaining_next = bytes_remaining;
    type_value_next      = type_value;
    dbit_flag_next       = dbit_flag;
    crc_accum_next       = crc_accum;
    received_crc_next    = received_crc;
    sndu_active_next     = sndu_active;
    cell_mode_next       = cell_mode;
    cell_bad_next        = cell_bad;
    cell_pusi_next       = cell_pusi;
    len_hi_next          = len_hi;
    emit_v               = 1'b0;
    emit_r               = '0;
    idx                  = '0;
    w                    = '0;
    rem_dec              = '0;
    do_sync_start        = 1'b0;

    if (in_valid) begin
      // Truncated cell.
      if (cell_start && cell_position != '0) begin
        emit_v               = 1'b1;
        emit_r.kind          = ule_pkg::K_ABORT;
        emit_r.fault_code    = ule_pkg::F_BAD_CELL;
        emit_r.last_of_sndu  = sndu_active_next;
        emit_r.sndu_type     = type_value_next;
        emit_r.dest_absent   = dbit_flag_next;
        emit_r.pdu_length    = sndu_active_next ? sndu_length_next - 15'd4 : '0;
        sndu_active_next     = 1'b0;
        sndu_length_next     = '0;
        bytes_remaining_next = '0;
        type_value_next      = '0;
        dbit_flag_next       = 1'b0;
        crc_accum_next       = '1;
        received_crc_next    = '0;
        parse_phase_next     = ule_pkg::PH_LEN_HI;
        pointer_skip_next    = '0;
        need_sync_next       = 1'b1;
      end
      idx = cell_start ? '0 : cell_position;

      if (idx == 0) begin
        cell_bad_next  = (ts_byte != ule_pkg::SYNC_MARK);
        cell_pusi_next = 1'b0;
        cell_mode_next = ule_pkg::MODE_HDR;
      end else if (idx == 1) begin
        if (ts_byte[7]) cell_bad_next = 1'b1;
        cell_pusi_next = ts_byte[6];
      end else if (idx == 3) begin
        // Header decision.
        if (cell_bad || ts_byte[7:6] != 2'b00) begin
          if (!emit_v) begin
            emit_v              = 1'b1;
            emit_r.kind         = ule_pkg::K_ABORT;
            emit_r.fault_code   = ule_pkg::F_BAD_CELL;
            emit_r.last_of_sndu = sndu_active;
            emit_r.sndu_type    = type_value;
            emit_r.dest_absent  = dbit_flag;
            emit_r.pdu_length   = sndu_active ? sndu_length - 15'd4 : '0;
          end
          sndu_active_next     = 1'b0;
          sndu_length_next     = '0;
          bytes_remaining_next = '0;
          type_value_next      = '0;
          dbit_flag_next       = 1'b0;
          crc_accum_next       = '1;
          received_crc_next    = '0;
          parse_phase_next     = ule_pkg::PH_LEN_HI;
          pointer_skip_next    = '0;
          need_sync_next       = 1'b1;
          cell_mode_next       = ule_pkg::MODE_SKIP;
        end else if (!need_sync && ts_byte[3:0] == expected_cc) begin
          expected_cc_next = ts_byte[3:0] + 4'd1;
          cell_mode_next   = cell_pusi ? ule_pkg::MODE_PTR_PACKED : ule_pkg::MODE_DATA;
        end else begin
          if (!need_sync) begin
            emit_v               = 1'b1;
            emit_r.kind          = ule_pkg::K_ABORT;
            emit_r.fault_code    = ule_pkg::F_CC_GAP;
            emit_r.last_of_sndu  = sndu_active;
            emit_r.sndu_type     = type_value;
            emit_r.dest_absent   = dbit_flag;
            emit_r.pdu_length    = sndu_active ? sndu_length - 15'd4 : '0;
            sndu_active_next     = 1'b0;
            sndu_length_next     = '0;
            bytes_remaining_next = '0;
            type_value_next      = '0;
            dbit_flag_next       = 1'b0;
            crc_accum_next       = '1;
            received_crc_next    = '0;
            parse_phase_next     = ule_pkg::PH_LEN_HI;
            pointer_skip_next    = '0;
            need_sync_next       = 1'b1;
          end
          if (cell_pusi) begin
            expected_cc_next = ts_byte[3:0] + 4'd1;
            cell_mode_next   = ule_pkg::MODE_PTR_SYNC;
          end else begin
            cell_mode_next = ule_pkg::MODE_SKIP;
          end
        end
      end else if (idx == 4 && cell_mode == ule_pkg::MODE_PTR_SYNC) begin
        do_sync_start = 1'b1;
      end else if (idx == 4 && cell_mode == ule_pkg::MODE_PTR_PACKED) begin
        if (ts_byte >= ule_pkg::PTR_LIMIT || {8'd0, ts_byte} != bytes_remaining) begin
          emit_v               = 1'b1;
          emit_r.kind          = ule_pkg::K_ABORT;
          emit_r.fault_code    = (ts_byte >= ule_pkg::PTR_LIMIT) ? ule_pkg::F_BAD_PTR
                                                                 : ule_pkg::F_INCOMPLETE;
          emit_r.last_of_sndu  = sndu_active;
          emit_r.sndu_type     = type_value;
          emit_r.dest_absent   = dbit_flag;
          emit_r.pdu_length    = sndu_active ? sndu_length - 15'd4 : '0;
          do_sync_start        = 1'b1;
        end else begin
          cell_mode_next = ule_pkg::MODE_DATA;
        end
      end else if (idx >= 4 && idx <= ule_pkg::LAST_PAYLOAD[ule_pkg::POS_W-1:0]
                   && cell_mode == ule_pkg::MODE_DATA) begin
        if (pointer_skip != '0) begin
          pointer_skip_next = pointer_skip - 8'd1;
        end else begin
          case (parse_phase)
            ule_pkg::PH_LEN_HI: begin
              if (idx < ule_pkg::LAST_PAYLOAD[ule_pkg::POS_W-1:0]) begin
                len_hi_next      = ts_byte;
                parse_phase_next = ule_pkg::PH_LEN_LO;
              end
            end
            ule_pkg::PH_LEN_LO: begin
              w = {len_hi, ts_byte};
              if (w == 16'hFFFF) begin
                parse_phase_next = ule_pkg::PH_PAD;
              end else if (w[14:0] < ule_pkg::MIN_LEN) begin
                // Short length: sndu is never open here.
                emit_v               = 1'b1;
                emit_r.kind          = ule_pkg::K_ABORT;
                emit_r.fault_code    = ule_pkg::F_SHORT;
                emit_r.sndu_type     = type_value;
                emit_r.dest_absent   = dbit_flag;
                sndu_length_next     = '0;
                bytes_remaining_next = '0;
                type_value_next      = '0;
                dbit_flag_next       = 1'b0;
                crc_accum_next       = '1;
                received_crc_next    = '0;
                pointer_skip_next    = '0;
                need_sync_next       = 1'b1;
                parse_phase_next     = ule_pkg::PH_PAD;
              end else begin
                sndu_active_next     = 1'b1;
                dbit_flag_next       = w[15];
                sndu_length_next     = w[14:0];
                bytes_remaining_next = {1'b0, w[14:0]} + 16'd2;
                crc_accum_next       = ule_pkg::crc_byte(ule_pkg::crc_byte('1, len_hi),
                                                         ts_byte);
                parse_phase_next     = ule_pkg::PH_TYPE_HI;
              end
            end
            ule_pkg::PH_TYPE_HI: begin
              type_value_next      = {ts_byte, 8'd0};
              crc_accum_next       = ule_pkg::crc_byte(crc_accum, ts_byte);
              bytes_remaining_next = bytes_remaining - 16'd1;
              parse_phase_next     = ule_pkg::PH_TYPE_LO;
            end
            ule_pkg::PH_TYPE_LO: begin
              type_value_next      = {type_value[15:8], ts_byte};
              crc_accum_next       = ule_pkg::crc_byte(crc_accum, ts_byte);
              bytes_remaining_next = bytes_remaining - 16'd1;
              parse_phase_next     = ule_pkg::PH_PDU;
            end
            ule_pkg::PH_PDU: begin
              rem_dec = (bytes_remaining != '0) ? bytes_remaining - 16'd1 : '0;
              bytes_remaining_next = rem_dec;
              if (bytes_remaining > 16'd4) begin
                crc_accum_next     = ule_pkg::crc_byte(crc_accum, ts_byte);
                emit_v             = 1'b1;
                emit_r.kind        = ule_pkg::K_PDU;
                emit_r.pdu_byte    = ts_byte;
                emit_r.sndu_type   = type_value;
                emit_r.dest_absent = dbit_flag;
                emit_r.pdu_length  = sndu_active ? sndu_length - 15'd4 : '0;
              end else begin
                received_crc_next = {received_crc[23:0], ts_byte};
              end
              if (rem_dec == '0) begin
                if (!emit_v) begin
                  emit_v              = 1'b1;
                  emit_r.kind         = (crc_accum_next == received_crc_next) ?
                                        ule_pkg::K_GOOD : ule_pkg::K_BAD;
                  emit_r.last_of_sndu = 1'b1;
                  emit_r.sndu_type    = type_value;
                  emit_r.dest_absent  = dbit_flag;
                  emit_r.pdu_length   = sndu_active ? sndu_length - 15'd4 : '0;
                end
                sndu_active_next     = 1'b0;
                sndu_length_next     = '0;
                bytes_remaining_next = '0;
                type_value_next      = '0;
                dbit_flag_next       = 1'b0;
                crc_accum_next       = '1;
                received_crc_next    = '0;
                parse_phase_next     = ule_pkg::PH_LEN_HI;
                pointer_skip_next    = '0;
              end
            end
            default: ;
          endcase
        end
        if (idx == ule_pkg::LAST_PAYLOAD[ule_pkg::POS_W-1:0] && !sndu_active_next)
          need_sync_next = 1'b1;
      end

      // Resync at the pointer of a PUSI cell.
      if (do_sync_start) begin
        sndu_active_next     = 1'b0;
        sndu_length_next     = '0;
        bytes_remaining_next = '0;
        type_value_next      = '0;
        dbit_flag_next       = 1'b0;
        crc_accum_next       = '1;
        received_crc_next    = '0;
        parse_phase_next     = ule_pkg::PH_LEN_HI;
        pointer_skip_next    = '0;
        if (ts_byte > ule_pkg::PAYLOAD_BYTES || ts_byte > ule_pkg::PTR_LIMIT - 8'd2) begin
          if (!emit_v) begin
            emit_v              = 1'b1;
            emit_r.kind         = ule_pkg::K_ABORT;
            emit_r.fault_code   = (ts_byte > ule_pkg::PAYLOAD_BYTES) ? ule_pkg::F_BAD_PTR
                                                                     : ule_pkg::F_PACKING;
          end
          need_sync_next = 1'b1;
          cell_mode_next = ule_pkg::MODE_SKIP;
        end else begin
          need_sync_next    = 1'b0;
          pointer_skip_next = ts_byte;
          cell_mode_next    = ule_pkg::MODE_DATA;
        end
      end

      cell_position_next = ({1'b0, idx} + 1'b1 >= (ule_pkg::POS_W+1)'(ule_pkg::CELL_BYTES)) ?
                           '0 : idx + 1'b1;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_position   <= '0;
      need_sync       <= 1'b1;
      expected_cc     <= '0;
      parse_phase     <= ule_pkg::PH_LEN_HI;
      pointer_skip    <= '0;
      sndu_length     <= '0;
      bytes_remaining <= '0;
      type_value      <= '0;
      dbit_flag       <= 1'b0;
      crc_accum       <= '1;
      received_crc    <= '0;
      sndu_active     <= 1'b0;
      cell_mode       <= ule_pkg::MODE_SKIP;
      cell_bad        <= 1'b0;
      cell_pusi       <= 1'b0;
      len_hi          <= '0;
      res_valid       <= 1'b0;
    end else begin
      cell_position   <= cell_position_next;
      need_sync       <= need_sync_next;
      expected_cc     <= expected_cc_next;
      parse_phase     <= parse_phase_next;
      pointer_skip    <= pointer_skip_next;
      sndu_length     <= sndu_length_next;
      bytes_remaining <= bytes_remaining_next;
      type_value      <= type_value_next;
      dbit_flag       <= dbit_flag_next;
      crc_accum       <= crc_accum_next;
      received_crc    <= received_crc_next;
      sndu_active     <= sndu_active_next;
      cell_mode       <= cell_mode_next;
      cell_bad        <= cell_bad_next;
      cell_pusi       <= cell_pusi_next;
      len_hi          <= len_hi_next;
      res_valid       <= emit_v;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    res <= emit_r;
  end

endmodule
